[sv/orsc_pkg.sv]
package orsc_pkg;

    // default geometry
    localparam int KEY_COUNT_DEF = 1024;
    localparam int NUM_SLOTS_DEF = 16;

    // field widths
    localparam int KEY_W      = 10;
    localparam int SLOT_OUT_W = 5;
    localparam int OCC_W      = 5;
    localparam int LEN_W      = 11;
    localparam int DIST_W     = 13;
    localparam int CFG_IDX_W  = 1;

    // distance of a key that is never used again, ranks above every real distance
    localparam logic [DIST_W-1:0] DIST_NEVER = '1;

    localparam logic signed [SLOT_OUT_W-1:0] SLOT_NONE = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC    = 1'b1;

    localparam logic [LEN_W-1:0] TRACE_LEN_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic signed [SLOT_OUT_W-1:0] slot;
        logic [OCC_W-1:0]             occupied;
        logic                         key_error;
    } t_out_item;

    // key map memory controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_map_ctl;

    // slot table controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic fill;
        logic clear_all;
    } t_slot_ctl;

    // next-use distance of key k seen from trace position pos
    function automatic logic [DIST_W-1:0] f_dist(
        input logic [KEY_W-1:0] k,
        input logic [LEN_W-1:0] pos,
        input logic [LEN_W-1:0] len,
        input logic             cyc
    );
        logic [DIST_W-1:0] kx;
        logic [DIST_W-1:0] px;
        logic [DIST_W-1:0] lx;
        kx = DIST_W'(k);
        px = DIST_W'(pos);
        lx = DIST_W'(len);
        if (kx >= px) begin
            return kx - px;
        end else if (cyc) begin
            return lx - px + kx;
        end else begin
            return DIST_NEVER;
        end
    endfunction

endpackage

[sv/orsc_key_map.sv]
module orsc_key_map import orsc_pkg::*; #(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int KAW = $clog2(KEY_COUNT),
    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_map_ctl       i_ctl,
    input  logic [KAW-1:0] i_rd_addr,
    input  logic [KAW-1:0] i_wr_addr,
    input  logic [SW-1:0]  i_wr_slot,
    output logic [SW-1:0]  o_rd_slot,
    output logic           o_ready
);

    logic [SW-1:0]  mem [KEY_COUNT];
    logic [SW-1:0]  r_rd_slot;
    logic [KAW-1:0] r_sweep_addr;
    logic           r_sweeping;

    // sweep after reset so every entry holds a defined slot number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_sweeping   <= 1'b1;
        end else if (r_sweeping) begin
            if (r_sweep_addr == KAW'(KEY_COUNT - 1)) begin
                r_sweeping <= 1'b0;
            end else begin
                r_sweep_addr <= r_sweep_addr + KAW'(1);
            end
        end
    end

    // key to slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_sweeping) begin
            mem[r_sweep_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_slot;
        end
        if (i_ctl.rd_en) begin
            r_rd_slot <= mem[i_rd_addr];
        end
    end

    assign o_rd_slot = r_rd_slot;
    assign o_ready   = !r_sweeping;

`ifndef SYNTHESIS
    a_no_access_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr_en || i_ctl.rd_en) |-> !r_sweeping)
        else $error("key map accessed during sweep");
`endif

endmodule

[sv/orsc_slot_store.sv]
module orsc_slot_store import orsc_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int UW = $clog2(NUM_SLOTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_slot_ctl            i_ctl,
    input  logic [SW-1:0]        i_rd_addr,
    input  logic [SW-1:0]        i_wr_addr,
    input  logic [KEY_W-1:0]     i_wr_key,
    output logic [KEY_W-1:0]     o_rd_key,
    output logic [NUM_SLOTS-1:0] o_valid,
    output logic [SW-1:0]        o_free_slot,
    output logic                 o_any_free,
    output logic [UW-1:0]        o_used
);

    logic [KEY_W-1:0]     mem [NUM_SLOTS];
    logic [KEY_W-1:0]     r_rd_key;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [UW-1:0]        r_used;
    logic [SW-1:0]        free_slot;
    logic                 any_free;

    // slot to key memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_key;
        end
        if (i_ctl.rd_en) begin
            r_rd_key <= mem[i_rd_addr];
        end
    end

    // occupancy flags and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_ctl.clear_all) begin
            r_valid <= '0;
            r_used  <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.fill) begin
                r_used <= r_used + UW'(1);
            end
        end
    end

    // lowest empty slot
    always_comb begin
        free_slot = '0;
        any_free  = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SW'(i);
                any_free  = 1'b1;
            end
        end
    end

    assign o_rd_key    = r_rd_key;
    assign o_valid     = r_valid;
    assign o_free_slot = free_slot;
    assign o_any_free  = any_free;
    assign o_used      = r_used;

`ifndef SYNTHESIS
    a_fill_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.fill |-> (i_ctl.wr_en && !r_valid[i_wr_addr]))
        else $error("fill of an occupied slot");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(NUM_SLOTS))
        else $error("occupied count above slot count");
`endif

endmodule

[sv/orsc_ctrl.sv]
module orsc_ctrl import orsc_pkg::*; #(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int KAW = $clog2(KEY_COUNT),
    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int UW  = $clog2(NUM_SLOTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in_item             i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output t_out_item            o_result,
    input  logic [LEN_W-1:0]     i_len,
    input  logic                 i_cyclic,
    input  logic                 i_len_wr,
    input  logic                 i_init_done,
    output t_map_ctl             o_map_ctl,
    output logic [KAW-1:0]       o_map_rd_addr,
    output logic [KAW-1:0]       o_map_wr_addr,
    output logic [SW-1:0]        o_map_wr_slot,
    input  logic [SW-1:0]        i_map_rd_slot,
    output t_slot_ctl            o_slot_ctl,
    output logic [SW-1:0]        o_slot_rd_addr,
    output logic [SW-1:0]        o_slot_wr_addr,
    output logic [KEY_W-1:0]     o_slot_wr_key,
    input  logic [KEY_W-1:0]     i_slot_rd_key,
    input  logic [NUM_SLOTS-1:0] i_slot_valid,
    input  logic [SW-1:0]        i_free_slot,
    input  logic                 i_any_free,
    input  logic [UW-1:0]        i_used
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOK   = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_LAST   = 6'b010000,
        ST_DECIDE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic              r_err;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [SW-1:0]     r_idx;
    logic [SW-1:0]     r_cmp_slot;
    logic              r_cmp_vld;
    logic              r_any;
    logic [DIST_W-1:0] r_far;
    logic [SW-1:0]     r_victim;
    logic              r_done;
    t_out_item         r_result, n_result;

    logic              accept;
    logic              key_err_in;
    logic              hit;
    logic              fill_now;
    logic              evict_now;
    logic              finish;
    logic              upd;
    logic [DIST_W-1:0] cur_dist;
    logic [DIST_W-1:0] key_dist;
    logic [LEN_W:0]    pos_inc;

    assign o_busy = (r_state != ST_IDLE) || !i_init_done;
    assign accept = i_start && !o_busy;

    // key bound against the trace length and the map depth
    assign key_err_in = ({1'b0, i_item.key} >= i_len) || (32'(i_item.key) >= KEY_COUNT);

    // slot read back from the key map is live only if the slot still holds this key
    assign hit = i_slot_valid[i_map_rd_slot] && (i_slot_rd_key == r_key);

    assign fill_now  = (r_state == ST_CHECK) && (r_op == OP_ALLOC) && !hit && i_any_free;
    assign cur_dist  = f_dist(i_slot_rd_key, r_pos, i_len, i_cyclic);
    assign key_dist  = f_dist(r_key, r_pos, i_len, i_cyclic);
    assign evict_now = (r_state == ST_DECIDE) && (key_dist < r_far);
    assign upd       = r_cmp_vld && (!r_any || (cur_dist > r_far));
    assign pos_inc   = {1'b0, r_pos} + (LEN_W + 1)'(1);

    // memory ports
    always_comb begin
        o_map_ctl.rd_en = accept;
        o_map_ctl.wr_en = fill_now || evict_now;
        o_map_rd_addr   = KAW'(i_item.key);
        o_map_wr_addr   = KAW'(r_key);
        o_map_wr_slot   = fill_now ? i_free_slot : r_victim;

        o_slot_ctl.rd_en     = (r_state == ST_LOOK) || (r_state == ST_SCAN);
        o_slot_ctl.wr_en     = fill_now || evict_now;
        o_slot_ctl.fill      = fill_now;
        o_slot_ctl.clear_all = (r_state == ST_LOOK) && (r_op == OP_CLEAR);
        o_slot_rd_addr       = (r_state == ST_LOOK) ? i_map_rd_slot : r_idx;
        o_slot_wr_addr       = fill_now ? i_free_slot : r_victim;
        o_slot_wr_key        = r_key;
    end

    // sequencer and result
    always_comb begin
        n_state            = r_state;
        n_pos              = r_pos;
        finish             = 1'b0;
        n_result.slot      = SLOT_NONE;
        n_result.occupied  = OCC_W'(i_used);
        n_result.key_error = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (r_err || (r_op == OP_CLEAR) || (r_op == OP_NONE)) begin
                    finish             = 1'b1;
                    n_result.key_error = r_err;
                    if (r_op == OP_CLEAR) begin
                        n_result.occupied = '0;
                        n_pos             = '0;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_op == OP_LOOKUP) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                    if (hit) begin
                        n_result.slot = SLOT_OUT_W'(i_map_rd_slot);
                    end
                    n_pos = (pos_inc >= {1'b0, i_len}) ? '0 : pos_inc[LEN_W-1:0];
                end else if (hit) begin
                    finish        = 1'b1;
                    n_state       = ST_IDLE;
                    n_result.slot = SLOT_OUT_W'(i_map_rd_slot);
                end else if (i_any_free) begin
                    finish            = 1'b1;
                    n_state           = ST_IDLE;
                    n_result.slot     = SLOT_OUT_W'(i_free_slot);
                    n_result.occupied = OCC_W'(i_used) + OCC_W'(1);
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == SW'(NUM_SLOTS - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                finish  = 1'b1;
                n_state = ST_IDLE;
                if (evict_now) begin
                    n_result.slot = SLOT_OUT_W'(r_victim);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_done    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_any     <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= finish;
            if (i_len_wr) begin
                r_pos <= '0;
            end else begin
                r_pos <= n_pos;
            end
            if (r_state == ST_CHECK) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_any     <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_idx     <= r_idx + SW'(1);
                r_cmp_vld <= 1'b1;
            end
            if (upd && ((r_state == ST_SCAN) || (r_state == ST_LAST))) begin
                r_any <= 1'b1;
            end
        end
    end

    // item and scan payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_item.op;
            r_key <= i_item.key;
            r_err <= key_err_in && ((i_item.op == OP_LOOKUP) || (i_item.op == OP_ALLOC));
        end
        if (r_state == ST_SCAN) begin
            r_cmp_slot <= r_idx;
        end
        if (upd && ((r_state == ST_SCAN) || (r_state == ST_LAST))) begin
            r_far    <= cur_dist;
            r_victim <= r_cmp_slot;
        end
        if (finish) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == ST_LOOK || $past(r_state) == ST_CHECK
                    || $past(r_state) == ST_DECIDE))
        else $error("result beat from a non-final step");
    a_err_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.key_error) |-> (r_result.slot == SLOT_NONE))
        else $error("slot returned with key error");
`endif

endmodule

[sv/optimal_replacement_slot_cache_core.sv]
// lookup, allocate with a hit or a free slot: decided in CHECK after LOOK; clear,
// out-of-range key, unused op: decided in LOOK; allocate into a full cache: LOOK, CHECK,
// SCAN of every slot, LAST, DECIDE; the next start is taken in the strobe cycle, so a new
// item waits until the last is done; the full-cache scan reads one slot table entry per
// cycle through its single port; after reset busy stays high while the key map is swept
// results cannot be stalled; each result is a single-cycle beat on o_done
module optimal_replacement_slot_cache_core import orsc_pkg::*; #(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output logic                 o_done,
    output t_out_item            o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    localparam int KAW = $clog2(KEY_COUNT);
    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int UW  = $clog2(NUM_SLOTS + 1);

    logic [LEN_W-1:0]     r_trace_len;
    logic                 r_cyclic;
    logic                 cfg_wr;
    logic                 len_wr;

    t_map_ctl             map_ctl;
    logic [KAW-1:0]       map_rd_addr;
    logic [KAW-1:0]       map_wr_addr;
    logic [SW-1:0]        map_wr_slot;
    logic [SW-1:0]        map_rd_slot;
    logic                 map_ready;

    t_slot_ctl            slot_ctl;
    logic [SW-1:0]        slot_rd_addr;
    logic [SW-1:0]        slot_wr_addr;
    logic [KEY_W-1:0]     slot_wr_key;
    logic [KEY_W-1:0]     slot_rd_key;
    logic [NUM_SLOTS-1:0] slot_valid;
    logic [SW-1:0]        free_slot;
    logic                 any_free;
    logic [UW-1:0]        used;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign len_wr      = cfg_wr && (i_cfg_index == CFG_TRACE_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_len <= TRACE_LEN_RST;
            r_cyclic    <= 1'b0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_TRACE_LEN: r_trace_len <= i_cfg_data;
                CFG_CYCLIC:    r_cyclic    <= i_cfg_data[0];
                default:       r_cyclic    <= r_cyclic;
            endcase
        end
    end

    orsc_ctrl #(
        .KEY_COUNT (KEY_COUNT),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_item         (i_item),
        .o_busy         (busy),
        .o_done         (o_done),
        .o_result       (o_result),
        .i_len          (r_trace_len),
        .i_cyclic       (r_cyclic),
        .i_len_wr       (len_wr),
        .i_init_done    (map_ready),
        .o_map_ctl      (map_ctl),
        .o_map_rd_addr  (map_rd_addr),
        .o_map_wr_addr  (map_wr_addr),
        .o_map_wr_slot  (map_wr_slot),
        .i_map_rd_slot  (map_rd_slot),
        .o_slot_ctl     (slot_ctl),
        .o_slot_rd_addr (slot_rd_addr),
        .o_slot_wr_addr (slot_wr_addr),
        .o_slot_wr_key  (slot_wr_key),
        .i_slot_rd_key  (slot_rd_key),
        .i_slot_valid   (slot_valid),
        .i_free_slot    (free_slot),
        .i_any_free     (any_free),
        .i_used         (used)
    );

    orsc_key_map #(
        .KEY_COUNT (KEY_COUNT),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_key_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (map_ctl),
        .i_rd_addr (map_rd_addr),
        .i_wr_addr (map_wr_addr),
        .i_wr_slot (map_wr_slot),
        .o_rd_slot (map_rd_slot),
        .o_ready   (map_ready)
    );

    orsc_slot_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (slot_ctl),
        .i_rd_addr   (slot_rd_addr),
        .i_wr_addr   (slot_wr_addr),
        .i_wr_key    (slot_wr_key),
        .o_rd_key    (slot_rd_key),
        .o_valid     (slot_valid),
        .o_free_slot (free_slot),
        .o_any_free  (any_free),
        .o_used      (used)
    );

endmodule

[verif/tb_top.sv]
module tb_top import orsc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int unsigned PHASE_LEN  = 240;
    localparam int unsigned DRAIN_WAIT = 24;

    // belady cache predictor and the queue of results it still waits for
    class cache_tracker;
        logic [LEN_W-1:0] trace_len;
        bit               cyc;
        bit               key_held[KEY_COUNT_DEF];
        int unsigned      key_slot[KEY_COUNT_DEF];
        bit               slot_held[NUM_SLOTS_DEF];
        int unsigned      slot_key[NUM_SLOTS_DEF];
        int unsigned      pos;
        int unsigned      used;
        t_out_item        pending[$];
        int unsigned      errors;

        function new();
            trace_len = TRACE_LEN_RST;
            cyc       = 1'b0;
            errors    = 0;
            wipe();
        endfunction

        // empty both maps and rewind the trace
        function void wipe();
            foreach (key_held[i]) key_held[i] = 1'b0;
            foreach (slot_held[i]) slot_held[i] = 1'b0;
            pos  = 0;
            used = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
            if (idx == CFG_TRACE_LEN) begin
                trace_len = data;
                pos       = 0;
            end else if (idx == CFG_CYCLIC) begin
                cyc = data[0];
            end
        endfunction

        // next-use distance of a key from the current trace position
        function int unsigned ahead(int unsigned k);
            if (k >= pos) begin
                return k - pos;
            end
            if (cyc) begin
                return int'(trace_len) - pos + k;
            end
            return 32'hFFFF_FFFF;
        endfunction

        function void note_item(t_in_item it);
            t_out_item   want;
            int unsigned k;
            int unsigned bound;
            int unsigned far_dist;
            int unsigned d;
            int unsigned victim;
            bit          found;
            want.slot      = SLOT_NONE;
            want.key_error = 1'b0;
            k     = it.key;
            bound = (trace_len < KEY_COUNT_DEF) ? trace_len : KEY_COUNT_DEF;
            if (it.op == OP_CLEAR) begin
                wipe();
            end else if (it.op == OP_LOOKUP || it.op == OP_ALLOC) begin
                if (k >= bound) begin
                    want.key_error = 1'b1;
                end else if (it.op == OP_LOOKUP) begin
                    if (key_held[k]) want.slot = SLOT_OUT_W'(key_slot[k]);
                    pos = (pos + 1 >= trace_len) ? 0 : pos + 1;
                end else if (key_held[k]) begin
                    want.slot = SLOT_OUT_W'(key_slot[k]);
                end else begin
                    // lowest empty slot first
                    found = 1'b0;
                    for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
                        if (!found && !slot_held[s]) begin
                            slot_held[s] = 1'b1;
                            slot_key[s]  = k;
                            key_held[k]  = 1'b1;
                            key_slot[k]  = s;
                            used++;
                            want.slot = SLOT_OUT_W'(s);
                            found     = 1'b1;
                        end
                    end
                    // full: first slot with the farthest next use, if farther than the new key
                    if (!found) begin
                        far_dist = 0;
                        victim   = 0;
                        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
                            d = ahead(slot_key[s]);
                            if (s == 0 || d > far_dist) begin
                                far_dist = d;
                                victim   = s;
                            end
                        end
                        if (ahead(k) < far_dist) begin
                            key_held[slot_key[victim]] = 1'b0;
                            slot_key[victim] = k;
                            key_held[k]      = 1'b1;
                            key_slot[k]      = victim;
                            want.slot        = SLOT_OUT_W'(victim);
                        end
                    end
                end
            end
            want.occupied = OCC_W'(used);
            pending.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, got slot %0d occupied %0d %s %0d",
                         $time, got.slot, got.occupied, "key_error", got.key_error);
            end else begin
                want = pending.pop_front();
                if (got.slot !== want.slot || got.occupied !== want.occupied ||
                    got.key_error !== want.key_error) begin
                    errors++;
                    $display("%0t mismatch: expected slot %0d occupied %0d key_error %0d,",
                             $time, want.slot, want.occupied, want.key_error,
                             " got slot %0d occupied %0d key_error %0d",
                             got.slot, got.occupied, got.key_error);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in_item             i_item      = '0;
    logic                 o_done;
    t_out_item            o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data  = '0;

    cache_tracker tracker = new();
    bit           idle_on = 1'b1;
    int unsigned  cycles  = 0;

    optimal_replacement_slot_cache_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watch accepted beats on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) tracker.check_result(o_result);
            if (start && !busy) tracker.note_item(i_item);
            if (i_cfg_valid && o_cfg_ready) tracker.set_register(i_cfg_index, i_cfg_data);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one command beat, with an occasional idle gap ahead of it
    task automatic send(t_op op, int unsigned key);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{op: op, key: KEY_W'(key)};
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every expected result is in, then let the block settle
    task automatic settle();
        start <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // one register beat, then the channel goes quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= LEN_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random traffic for one trace length: mostly in-range lookups and allocates
    task automatic run_phase(int unsigned len, int unsigned n);
        int unsigned r;
        int unsigned k;
        int unsigned span;
        t_op         op;
        int unsigned recent[$];
        for (int i = 0; i < n; i++) begin
            r  = $urandom_range(0, 99);
            op = ($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_LOOKUP;
            if (r < 1) begin
                op = OP_CLEAR;
                k  = $urandom_range(0, KEY_COUNT_DEF - 1);
            end else if (r < 3) begin
                op = OP_NONE;
                k  = $urandom_range(0, KEY_COUNT_DEF - 1);
            end else if (r < 9 && len < KEY_COUNT_DEF) begin
                k = $urandom_range(len, KEY_COUNT_DEF - 1);
            end else if (op == OP_LOOKUP && recent.size() > 0 && $urandom_range(0, 99) < 60) begin
                k = recent[$urandom_range(0, recent.size() - 1)];
            end else if ($urandom_range(0, 1) != 0) begin
                // keys just ahead of the trace position compete for eviction
                span = (len < 48) ? len : 48;
                k    = (tracker.pos + $urandom_range(0, span - 1)) % len;
            end else begin
                k = $urandom_range(0, len - 1);
            end
            if (op == OP_ALLOC) begin
                recent.push_back(k);
                if (recent.size() > 24) void'(recent.pop_front());
            end
            send(op, k);
        end
    endtask

    // stimulus
    initial begin
        int unsigned lens[8];
        bit          cycs[8];
        lens = '{20, 1, 1024, 16, 40, 1024, 7, 300};
        cycs = '{1, 0, 1, 0, 1, 0, 1, 1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: hits, misses, repeat allocate, unused op, clear, fill and evict
        send(OP_LOOKUP, 0);
        send(OP_ALLOC, 0);
        send(OP_LOOKUP, 0);
        send(OP_ALLOC, 0);
        send(OP_ALLOC, 1023);
        send(OP_LOOKUP, 1023);
        send(OP_NONE, 1023);
        send(OP_CLEAR, 1023);
        for (int k = 0; k < NUM_SLOTS_DEF; k++) send(OP_ALLOC, 100 + k * 60);
        send(OP_ALLOC, 1023);
        send(OP_ALLOC, 5);
        send(OP_LOOKUP, 5);

        // shorter trace: out-of-range keys, then an in-range allocate
        settle();
        write_reg(CFG_TRACE_LEN, 16);
        send(OP_ALLOC, 1023);
        send(OP_LOOKUP, 16);
        send(OP_ALLOC, 3);

        // random phases across trace settings, one of them without idling
        foreach (lens[p]) begin
            settle();
            write_reg(CFG_TRACE_LEN, lens[p]);
            write_reg(CFG_CYCLIC, cycs[p]);
            idle_on = (p != 2);
            run_phase(lens[p], PHASE_LEN);
        end

        settle();
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/orsc_pkg.sv
sv/orsc_key_map.sv
sv/orsc_slot_store.sv
sv/orsc_ctrl.sv
sv/optimal_replacement_slot_cache_core.sv
verif/tb_top.sv
